// ===== design/u8sd_pkg.sv =====
package u8sd_pkg;

  localparam int MAX_BYTES = 65536;

  localparam int CP_W   = 21;
  localparam int RAW_W  = 32;
  localparam int WID_W  = 3;
  localparam int CNT_W  = 17;
  localparam int LEFT_W = 2;

  localparam int CNT_MAX_INT   = (2 ** CNT_W) - 1;
  localparam int COUNT_CAP_INT = (MAX_BYTES > CNT_MAX_INT) ? CNT_MAX_INT : MAX_BYTES;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(COUNT_CAP_INT);

  // byte class boundaries and payload masks
  localparam logic [7:0] ASCII_MAX = 8'h7f;
  localparam logic [7:0] LEAD2_MIN = 8'hc0;
  localparam logic [7:0] LEAD3_MIN = 8'he0;
  localparam logic [7:0] LEAD4_MIN = 8'hf0;
  localparam logic [7:0] CONT_MASK = 8'd63;
  localparam logic [7:0] LEAD2_MASK = 8'd31;
  localparam logic [7:0] LEAD3_MASK = 8'd15;
  localparam logic [7:0] LEAD4_MASK = 8'd7;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  localparam logic [WID_W-1:0] WID_1 = WID_W'(1);
  localparam logic [WID_W-1:0] WID_2 = WID_W'(2);
  localparam logic [WID_W-1:0] WID_3 = WID_W'(3);
  localparam logic [WID_W-1:0] WID_4 = WID_W'(4);

  // queue between classifier and decoder
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_STRAY
  } u8sd_cls_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } u8sd_in_t;

  typedef struct packed {
    logic [CP_W-1:0]  codepoint;
    logic [RAW_W-1:0] utf8_packed;
    logic [WID_W-1:0] seq_width;
    logic [CNT_W-1:0] codepoint_count;
    logic             bad;
    logic             all_ascii;
    logic             final_res;
  } u8sd_out_t;

  // classified word: byte, end mark, class and the payload bits of the byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    u8sd_cls_e  cls;
    logic [5:0] bits;
  } u8sd_cls_t;

endpackage

// ===== design/u8sd_front.sv =====
module u8sd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  u8sd_pkg::u8sd_in_t  in_word_i,
  output logic                push_o,
  output u8sd_pkg::u8sd_cls_t push_word_o,
  input  logic                q_full_i
);
  import u8sd_pkg::*;

  logic      stage_valid_q, stage_valid_d;
  u8sd_cls_t stage_q;
  u8sd_cls_t cls_word;
  logic      accept;

  always_comb begin
    cls_word.data_byte = in_word_i.data_byte;
    cls_word.last      = in_word_i.end_of_string;
    priority if (in_word_i.data_byte <= ASCII_MAX) begin
      cls_word.cls  = CLS_ASCII;
      cls_word.bits = 6'((in_word_i.data_byte & CONT_MASK));
    end else if (in_word_i.data_byte < LEAD2_MIN) begin
      // 10xxxxxx: continuation in a sequence, stray as a lead
      cls_word.cls  = CLS_CONT;
      cls_word.bits = 6'((in_word_i.data_byte & CONT_MASK));
    end else if (in_word_i.data_byte < LEAD3_MIN) begin
      cls_word.cls  = CLS_LEAD2;
      cls_word.bits = 6'((in_word_i.data_byte & LEAD2_MASK));
    end else if (in_word_i.data_byte < LEAD4_MIN) begin
      cls_word.cls  = CLS_LEAD3;
      cls_word.bits = 6'((in_word_i.data_byte & LEAD3_MASK));
    end else begin
      cls_word.cls  = CLS_LEAD4;
      cls_word.bits = 6'((in_word_i.data_byte & LEAD4_MASK));
    end
  end

  assign push_o      = stage_valid_q && !q_full_i;
  assign push_word_o = stage_q;
  assign in_stall_o  = stage_valid_q && q_full_i;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (accept) begin
      stage_valid_d = 1'b1;
    end else if (push_o) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= cls_word;
    end
  end

endmodule

// ===== design/u8sd_queue.sv =====
module u8sd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  u8sd_pkg::u8sd_cls_t push_word_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output u8sd_pkg::u8sd_cls_t head_o
);
  import u8sd_pkg::*;

  u8sd_cls_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + QCNT_W'(1);
      2'b01:   count_d = count_q - QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

// ===== design/u8sd_back.sv =====
module u8sd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  u8sd_pkg::u8sd_cls_t q_head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output u8sd_pkg::u8sd_out_t out_word_o
);
  import u8sd_pkg::*;

  logic [LEFT_W-1:0] left_q, left_d;
  logic [CP_W-1:0]   val_q, val_d;
  logic [RAW_W-1:0]  raw_q, raw_d;
  logic [WID_W-1:0]  wid_q, wid_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              wide_q, wide_d;
  logic              err_q, err_d;
  logic              out_valid_q;
  u8sd_out_t         out_q;

  logic [LEFT_W-1:0] acc_left;
  logic [CP_W-1:0]   acc_val;
  logic [RAW_W-1:0]  acc_raw;
  logic [WID_W-1:0]  acc_wid;
  logic              do_emit, do_err, emit;
  logic [CNT_W-1:0]  cnt_inc;
  logic              wide_new;
  u8sd_out_t         res;
  logic              last;

  assign pop_o       = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign last        = q_head_i.last;

  // decode of the byte at the head of the queue
  always_comb begin
    acc_left = left_q;
    acc_val  = val_q;
    acc_raw  = raw_q;
    acc_wid  = wid_q;
    do_emit  = 1'b0;
    do_err   = 1'b0;
    if (left_q == '0) begin
      acc_raw = RAW_W'(q_head_i.data_byte);
      acc_val = CP_W'(q_head_i.bits);
      unique case (q_head_i.cls)
        CLS_ASCII: begin
          acc_val = CP_W'(q_head_i.data_byte);
          acc_wid = WID_1;
          do_emit = 1'b1;
        end
        CLS_LEAD2: begin
          acc_wid  = WID_2;
          acc_left = LEFT_W'(1);
        end
        CLS_LEAD3: begin
          acc_wid  = WID_3;
          acc_left = LEFT_W'(2);
        end
        CLS_LEAD4: begin
          acc_wid  = WID_4;
          acc_left = LEFT_W'(3);
        end
        default: do_err = 1'b1;
      endcase
    end else begin
      if (q_head_i.cls != CLS_CONT) begin
        do_err = 1'b1;
      end else begin
        acc_val  = {val_q[CP_W-7:0], q_head_i.bits};
        acc_raw  = {raw_q[RAW_W-9:0], q_head_i.data_byte};
        acc_left = left_q - LEFT_W'(1);
        do_emit  = (left_q == LEFT_W'(1));
      end
    end
    // string ends inside a sequence
    if (!do_emit && last) begin
      do_err = 1'b1;
    end
  end

  assign cnt_inc  = (cnt_q < COUNT_CAP) ? cnt_q + CNT_W'(1) : cnt_q;
  assign wide_new = wide_q || (acc_wid > WID_1);

  always_comb begin
    left_d = left_q;
    val_d  = val_q;
    raw_d  = raw_q;
    wid_d  = wid_q;
    cnt_d  = cnt_q;
    wide_d = wide_q;
    err_d  = err_q;
    emit   = 1'b0;
    res    = '0;
    if (pop_o) begin
      if (err_q || do_err) begin
        if (last) begin
          emit                = 1'b1;
          res.codepoint_count = cnt_q;
          res.bad             = 1'b1;
          res.final_res       = 1'b1;
          left_d = '0;
          val_d  = '0;
          raw_d  = '0;
          wid_d  = '0;
          cnt_d  = '0;
          wide_d = 1'b0;
          err_d  = 1'b0;
        end else begin
          err_d  = 1'b1;
          left_d = '0;
        end
      end else if (do_emit) begin
        emit                = 1'b1;
        res.codepoint       = acc_val;
        res.utf8_packed     = acc_raw;
        res.seq_width       = acc_wid;
        res.codepoint_count = cnt_inc;
        res.all_ascii       = last && !wide_new;
        res.final_res       = last;
        left_d = '0;
        val_d  = '0;
        raw_d  = '0;
        wid_d  = '0;
        cnt_d  = last ? '0 : cnt_inc;
        wide_d = last ? 1'b0 : wide_new;
      end else begin
        left_d = acc_left;
        val_d  = acc_val;
        raw_d  = acc_raw;
        wid_d  = acc_wid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      val_q       <= '0;
      raw_q       <= '0;
      wid_q       <= '0;
      cnt_q       <= '0;
      wide_q      <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      left_q <= left_d;
      val_q  <= val_d;
      raw_q  <= raw_d;
      wid_q  <= wid_d;
      cnt_q  <= cnt_d;
      wide_q <= wide_d;
      err_q  <= err_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

endmodule

// ===== design/utf8_stream_decoder.sv =====
// channel | direction | handshake              | word
// in      | input     | in_valid_i / in_stall_o  | u8sd_in_t  (data_byte, end_of_string)
// out     | output    | out_valid_o / out_stall_i | u8sd_out_t (codepoint .. final_res)
//
// One byte per cycle while in_stall_o is low. A byte that completes a result passes
// the classify register, a queue entry and the output register before out_valid_o.
// The decoder consumes one queued byte per cycle while its output is not stalled; the
// sequence state it keeps is what orders the bytes.
// Reset is asynchronous, active low, and clears all string state.
// A stalled output holds its word; the queue and the classify stage keep taking
// bytes until the queue is full, then in_stall_o rises.
module utf8_stream_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  u8sd_pkg::u8sd_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output u8sd_pkg::u8sd_out_t out_word_o
);
  import u8sd_pkg::*;

  logic      push, q_full, pop, q_valid;
  u8sd_cls_t push_word, q_head;

  u8sd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .push_o      (push),
    .push_word_o (push_word),
    .q_full_i    (q_full)
  );

  u8sd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  u8sd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== design/u8sd_checker.sv =====
module u8sd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input u8sd_pkg::u8sd_in_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input u8sd_pkg::u8sd_out_t out_word_o
);
  import u8sd_pkg::*;

  // input word holds while stalled
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("input word changed under stall");

  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed under stall");

  // nothing comes out while in reset
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // error result is final and carries no sequence
  a_bad_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.bad |->
      out_word_o.final_res && !out_word_o.all_ascii &&
      out_word_o.codepoint == '0 && out_word_o.utf8_packed == '0 &&
      out_word_o.seq_width == '0)
    else $error("malformed error result");

  // good result: width 1..4, nonzero ordinal, ascii flag only on final and width 1
  a_good_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.bad |->
      out_word_o.seq_width != '0 && out_word_o.seq_width <= WID_4 &&
      out_word_o.codepoint_count != '0 &&
      (out_word_o.final_res || !out_word_o.all_ascii) &&
      (!out_word_o.all_ascii || out_word_o.seq_width == WID_1))
    else $error("malformed codepoint result");

endmodule

bind utf8_stream_decoder u8sd_checker u_chk (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import u8sd_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int ITEM_TARGET = 1900;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;

  logic clk_i;
  logic rst_ni;

  logic      in_valid = 1'b0;
  logic      in_stall;
  u8sd_in_t  in_word  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  u8sd_out_t out_word;

  utf8_stream_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  // pending bytes and expected codepoint words
  u8sd_in_t  byte_q[$];
  u8sd_out_t cp_expect_q[$];

  int err_cnt    = 0;
  int cycle_cnt  = 0;
  int byte_cnt   = 0;
  int string_cnt = 0;
  int result_cnt = 0;
  int flagged_cnt = 0;
  int wide_cnt   = 0;

  // shadow decoder state
  logic [LEFT_W-1:0] left_q;
  logic [CP_W-1:0]   val_acc;
  logic [RAW_W-1:0]  raw_acc;
  logic [WID_W-1:0]  cur_w;
  logic [CNT_W-1:0]  good_cnt;
  logic              wide_seen;
  logic              err_seen;

  task automatic clear_string();
    left_q    = '0;
    val_acc   = '0;
    raw_acc   = '0;
    cur_w     = '0;
    good_cnt  = '0;
    wide_seen = 1'b0;
    err_seen  = 1'b0;
  endtask

  task automatic flag_error(input logic fin);
    u8sd_out_t r;
    if (!fin) begin
      err_seen = 1'b1;
      left_q   = '0;
    end else begin
      r                 = '0;
      r.codepoint_count = good_cnt;
      r.bad             = 1'b1;
      r.final_res       = 1'b1;
      cp_expect_q.push_back(r);
      flagged_cnt++;
      string_cnt++;
      clear_string();
    end
  endtask

  task automatic emit_cp(input logic fin);
    u8sd_out_t r;
    if (good_cnt < COUNT_CAP) good_cnt++;
    if (cur_w > WID_1) begin
      wide_seen = 1'b1;
      wide_cnt++;
    end
    r.codepoint       = val_acc;
    r.utf8_packed     = raw_acc;
    r.seq_width       = cur_w;
    r.codepoint_count = good_cnt;
    r.bad             = 1'b0;
    r.all_ascii       = fin & ~wide_seen;
    r.final_res       = fin;
    cp_expect_q.push_back(r);
    left_q  = '0;
    val_acc = '0;
    raw_acc = '0;
    cur_w   = '0;
    if (fin) begin
      string_cnt++;
      clear_string();
    end
  endtask

  task automatic decode_byte(input u8sd_in_t w);
    logic [7:0] b;
    logic       fin;
    b   = w.data_byte;
    fin = w.end_of_string;
    if (err_seen) begin
      flag_error(fin);
    end else if (left_q == '0) begin
      raw_acc = RAW_W'(b);
      if (b <= ASCII_MAX) begin
        val_acc = CP_W'(b);
        cur_w   = WID_1;
        emit_cp(fin);
      end else if (b < LEAD2_MIN) begin
        flag_error(fin);
      end else begin
        if (b < LEAD3_MIN) begin
          val_acc = CP_W'(b & LEAD2_MASK);
          cur_w   = WID_2;
        end else if (b < LEAD4_MIN) begin
          val_acc = CP_W'(b & LEAD3_MASK);
          cur_w   = WID_3;
        end else begin
          val_acc = CP_W'(b & LEAD4_MASK);
          cur_w   = WID_4;
        end
        left_q = LEFT_W'(cur_w - WID_1);
        if (fin) flag_error(1'b1);
      end
    end else if (b[7:6] != CONT_TAG) begin
      flag_error(fin);
    end else begin
      val_acc = CP_W'({val_acc, 6'b0} | CP_W'(b & CONT_MASK));
      raw_acc = {raw_acc[RAW_W-9:0], b};
      left_q  = left_q - 1'b1;
      if (left_q == '0) emit_cp(fin);
      else if (fin) flag_error(1'b1);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
      err_cnt++;
    end
  endtask

  // stimulus building
  task automatic push_string(input logic [7:0] s[$]);
    u8sd_in_t w;
    foreach (s[i]) begin
      w.data_byte     = s[i];
      w.end_of_string = (i == s.size() - 1);
      byte_q.push_back(w);
    end
  endtask

  function automatic logic [7:0] cont_byte();
    return {CONT_TAG, 6'($urandom)};
  endfunction

  function automatic logic [7:0] lead_byte(input int width);
    case (width)
      2: return 8'($urandom_range(LEAD2_MIN, LEAD3_MIN - 1));
      3: return 8'($urandom_range(LEAD3_MIN, LEAD4_MIN - 1));
      default: return 8'($urandom_range(LEAD4_MIN, 8'hff));
    endcase
  endfunction

  task automatic add_random_string();
    logic [7:0] s[$];
    logic [7:0] b;
    int n_cp;
    int kind;
    int width;
    int n_cont;
    bit cut;
    n_cp = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
    cut  = ($urandom_range(0, 14) == 0);
    for (int i = 0; i < n_cp; i++) begin
      kind = $urandom_range(0, 19);
      if (cut && i == n_cp - 1) kind = 7 + $urandom_range(0, 9);
      if (kind <= 6) begin
        s.push_back(8'($urandom_range(1, ASCII_MAX)));
      end else if (kind <= 16) begin
        width  = (kind <= 10) ? 2 : (kind <= 13) ? 3 : 4;
        n_cont = (cut && i == n_cp - 1) ? $urandom_range(0, width - 2) : width - 1;
        s.push_back(lead_byte(width));
        for (int j = 0; j < n_cont; j++) s.push_back(cont_byte());
      end else if (kind == 17) begin
        s.push_back(8'($urandom_range(8'h80, LEAD2_MIN - 1)));
      end else if (kind == 18) begin
        // lead followed by a byte that is not a continuation
        s.push_back(lead_byte($urandom_range(2, 4)));
        do b = 8'($urandom_range(1, 255)); while (b[7:6] == CONT_TAG);
        s.push_back(b);
      end else begin
        s.push_back(8'($urandom_range(1, 255)));
      end
    end
    push_string(s);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_word    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_word);
        byte_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (byte_q.size() != 0) begin
          in_valid <= 1'b1;
          in_word  <= byte_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern changes each time stall_tick wraps, plus one long hold-off
  logic [6:0] stall_tick = '0;
  int         stall_mode = 0;
  int         hold_left  = 0;
  bit         hold_done  = 1'b0;
  u8sd_out_t  exp_w;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_tick <= '0;
      stall_mode <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        result_cnt++;
        if (cp_expect_q.size() == 0) begin
          $error("unexpected result word, codepoint 0x%0h", out_word.codepoint);
          err_cnt++;
        end else begin
          exp_w = cp_expect_q.pop_front();
          check_field("codepoint", 32'(exp_w.codepoint), 32'(out_word.codepoint));
          check_field("utf8_packed", exp_w.utf8_packed, out_word.utf8_packed);
          check_field("seq_width", 32'(exp_w.seq_width), 32'(out_word.seq_width));
          check_field("codepoint_count", 32'(exp_w.codepoint_count),
                      32'(out_word.codepoint_count));
          check_field("bad", 32'(exp_w.bad), 32'(out_word.bad));
          check_field("all_ascii", 32'(exp_w.all_ascii), 32'(out_word.all_ascii));
          check_field("final_res", 32'(exp_w.final_res), 32'(out_word.final_res));
        end
      end
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick == '1) stall_mode <= $urandom_range(0, 3);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && result_cnt >= 150) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (stall_tick[2:0] < 3'd3);
        endcase
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d words still expected",
             cycle_cnt, cp_expect_q.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [7:0] s[$];
    clear_string();
    // ascii extremes, all-ascii flag
    s = '{8'h01, 8'h7f};                   push_string(s);
    // two-byte extremes
    s = '{8'hc0, 8'h80, 8'hdf, 8'hbf};     push_string(s);
    // three-byte minimum
    s = '{8'he0, 8'h80, 8'h80};            push_string(s);
    // four-byte with all payload bits set
    s = '{8'hff, 8'hbf, 8'hbf, 8'hbf};     push_string(s);
    // stray continuation as lead, then silence until the end
    s = '{8'h41, 8'h80, 8'h42};            push_string(s);
    // continuation without 10 tag mid-string
    s = '{8'hc3, 8'h41, 8'h42};            push_string(s);
    // string ends inside a sequence
    s = '{8'he2, 8'h82};                   push_string(s);
    // error on the last byte itself
    s = '{8'hbf};                          push_string(s);
    s = '{8'h41, 8'hc3, 8'hff};            push_string(s);
    while (byte_q.size() < ITEM_TARGET) add_random_string();

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || in_valid) @(posedge clk_i);
    while (cp_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("sent %0d bytes in %0d strings, checked %0d result words", byte_cnt,
             string_cnt, result_cnt);
    $display("%0d multi-byte codepoints, %0d strings ended flagged", wide_cnt, flagged_cnt);
    if (err_cnt == 0 && cp_expect_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/u8sd_pkg.sv
design/u8sd_front.sv
design/u8sd_queue.sv
design/u8sd_back.sv
design/utf8_stream_decoder.sv
design/u8sd_checker.sv
tb/tb.sv
